[src/gnafs_pkg.sv]
package gnafs_pkg;

    localparam int COORD_BITS      = 12;
    localparam int ANGLE_FRAC_BITS = 8;

    localparam int STEPS     = 24;
    localparam int TAB_FRAC  = 24;
    localparam int PRE_SHIFT = 16;

    localparam int NUM_COORDS = 8;
    localparam int NUM_PAIRS  = 4;

    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int DIST_BITS  = SQ_BITS + 1;
    localparam int XY_BITS    = COORD_BITS + PRE_SHIFT + 4;
    localparam int Z_BITS     = TAB_FRAC + 8;
    localparam int T_BITS     = TAB_FRAC + 10;
    localparam int RND_SHIFT  = TAB_FRAC - ANGLE_FRAC_BITS;
    localparam int R_BITS     = T_BITS - RND_SHIFT;
    localparam int ANGLE_BITS = ANGLE_FRAC_BITS + 9;
    localparam int DA_BITS    = ANGLE_BITS + 1;
    localparam int LIM_BITS   = 8;
    localparam int CMP_BITS   = DA_BITS + 1;

    localparam int CORDIC_STAGES = STEPS + 2;
    localparam int FRONT_STAGES  = 3;
    localparam int BACK_STAGES   = 2;
    localparam int PIPE_STAGES   = FRONT_STAGES + CORDIC_STAGES + BACK_STAGES;

    localparam int IN_TDATA_BITS  = ((NUM_COORDS * COORD_BITS + 7) / 8) * 8;
    localparam int RESULT_BITS    = 2 * ANGLE_BITS + 3;
    localparam int OUT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_BITS = 2;

    localparam logic [LIM_BITS-1:0] WIDE_LIMIT_RESET = LIM_BITS'(45);
    localparam logic [LIM_BITS-1:0] SWAP_LIMIT_RESET = LIM_BITS'(36);

    localparam logic signed [ANGLE_BITS-1:0] FULL_ANGLE  = ANGLE_BITS'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [ANGLE_BITS-1:0] NEG_FULL    = -FULL_ANGLE;
    localparam logic signed [ANGLE_BITS-1:0] RIGHT_ANGLE = ANGLE_BITS'(90 << ANGLE_FRAC_BITS);
    localparam logic signed [ANGLE_BITS-1:0] NEG_RIGHT   = -RIGHT_ANGLE;

    localparam logic signed [T_BITS-1:0] HALF_TURN_Z = T_BITS'(64'sd180 <<< TAB_FRAC);
    localparam logic signed [T_BITS-1:0] NEG_HALF_Z  = -HALF_TURN_Z;
    localparam logic signed [T_BITS-1:0] ROUND_HALF  = T_BITS'(64'sd1 <<< (RND_SHIFT - 1));

    // atan(2^-i) in degrees, 24 fraction bits
    localparam logic signed [Z_BITS-1:0] STEP_ANGLE [STEPS] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115
    };

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WIDE_LIMIT = 2'd0,
        CFG_SWAP_LIMIT = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic [1:0]                   near_pair;
        logic                         swapped;
        logic signed [ANGLE_BITS-1:0] angle_two;
        logic signed [ANGLE_BITS-1:0] angle_one;
    } t_result;

endpackage

[src/gnafs_cordic.sv]
module gnafs_cordic (
    input  logic                                    i_clk,
    input  logic                                    i_en,
    input  logic signed [gnafs_pkg::DIFF_BITS-1:0]  i_dx,
    input  logic signed [gnafs_pkg::DIFF_BITS-1:0]  i_dy,
    output logic signed [gnafs_pkg::ANGLE_BITS-1:0] o_angle
);

    localparam int DW   = gnafs_pkg::DIFF_BITS;
    localparam int XW   = gnafs_pkg::XY_BITS;
    localparam int ZW   = gnafs_pkg::Z_BITS;
    localparam int TW   = gnafs_pkg::T_BITS;
    localparam int RW   = gnafs_pkg::R_BITS;
    localparam int AW   = gnafs_pkg::ANGLE_BITS;
    localparam int NS   = gnafs_pkg::STEPS;
    localparam int PADX = XW - DW - 1 - gnafs_pkg::PRE_SHIFT;

    localparam logic signed [RW-1:0] SAT_HI = RW'(180 << gnafs_pkg::ANGLE_FRAC_BITS);
    localparam logic signed [RW-1:0] SAT_LO = -SAT_HI;

    logic signed [XW-1:0] r_x        [NS+1];
    logic signed [XW-1:0] r_y        [NS+1];
    logic signed [ZW-1:0] r_z        [NS+1];
    logic                 r_base_pos [NS+1];
    logic                 r_base_neg [NS+1];
    logic                 r_spec     [NS+1];
    logic signed [AW-1:0] r_sval     [NS+1];
    logic signed [AW-1:0] r_angle;

    logic signed [DW:0]   n_ex, n_ey, n_mx, n_my;
    logic signed [XW-1:0] n_x0, n_y0;
    logic                 n_neg, n_spec, n_base_pos, n_base_neg;
    logic signed [AW-1:0] n_sval;

    logic signed [TW-1:0] n_base, n_t;
    logic signed [RW-1:0] n_r;
    logic signed [AW-1:0] n_angle;

    // prepare: axis cases, fold into right half plane, prescale
    always_comb begin
        n_ex       = {i_dx[DW-1], i_dx};
        n_ey       = {i_dy[DW-1], i_dy};
        n_neg      = i_dx[DW-1];
        n_mx       = n_neg ? -n_ex : n_ex;
        n_my       = n_neg ? -n_ey : n_ey;
        n_base_pos = n_neg && !i_dy[DW-1];
        n_base_neg = n_neg && i_dy[DW-1];
        n_x0       = {{PADX{n_mx[DW]}}, n_mx, {gnafs_pkg::PRE_SHIFT{1'b0}}};
        n_y0       = {{PADX{n_my[DW]}}, n_my, {gnafs_pkg::PRE_SHIFT{1'b0}}};
        n_spec     = (i_dx == '0) || (i_dy == '0);
        if (i_dy == '0) begin
            n_sval = n_neg ? gnafs_pkg::FULL_ANGLE : '0;
        end else if (i_dy[DW-1]) begin
            n_sval = gnafs_pkg::NEG_RIGHT;
        end else begin
            n_sval = gnafs_pkg::RIGHT_ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]        <= n_x0;
            r_y[0]        <= n_y0;
            r_z[0]        <= '0;
            r_base_pos[0] <= n_base_pos;
            r_base_neg[0] <= n_base_neg;
            r_spec[0]     <= n_spec;
            r_sval[0]     <= n_sval;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_step
        logic signed [XW-1:0] xs, ys;
        logic                 up;

        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        assign up = !r_y[i][XW-1] && (r_y[i] != '0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (up) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + gnafs_pkg::STEP_ANGLE[i];
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - gnafs_pkg::STEP_ANGLE[i];
                end
                r_base_pos[i+1] <= r_base_pos[i];
                r_base_neg[i+1] <= r_base_neg[i];
                r_spec[i+1]     <= r_spec[i];
                r_sval[i+1]     <= r_sval[i];
            end
        end
    end

    // add quadrant base, round to output fraction, saturate
    always_comb begin
        if (r_base_pos[NS]) begin
            n_base = gnafs_pkg::HALF_TURN_Z;
        end else if (r_base_neg[NS]) begin
            n_base = gnafs_pkg::NEG_HALF_Z;
        end else begin
            n_base = '0;
        end
        n_t = {{(TW-ZW){r_z[NS][ZW-1]}}, r_z[NS]} + n_base + gnafs_pkg::ROUND_HALF;
        n_r = n_t[TW-1:gnafs_pkg::RND_SHIFT];
        if (n_r > SAT_HI) begin
            n_angle = gnafs_pkg::FULL_ANGLE;
        end else if (n_r < SAT_LO) begin
            n_angle = gnafs_pkg::NEG_FULL;
        end else begin
            n_angle = n_r[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= r_spec[NS] ? r_sval[NS] : n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

[src/gauge_needle_angle_from_segments_unit.sv]
// channel  direction  handshake                 payload
// s        in         i_s_tvalid / o_s_tready   i_s_tdata: segment pair coordinates
// m        out        o_m_tvalid / i_m_tready   o_m_tdata: angles, swap flag, near pair
// cfg      in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data: limit registers
//
// one item per cycle while o_s_tready is high; a result passes the front stages, then the
// 24-step cordic pipeline (one micro-rotation per stage), then the back stages
// reset clears all valid bits and loads the limits with 45 and 36 degrees
// while the output is stalled one more result moves into a skid register,
// then o_s_tready drops and the whole pipeline holds
module gauge_needle_angle_from_segments_unit (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_tvalid,
    output logic                                        o_s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [gnafs_pkg::IN_TDATA_BITS-1:0]         i_s_tdata,
    output logic                                        o_m_tvalid,
    input  logic                                        i_m_tready,
    // angle_one, angle_two, swapped, near_pair, zero fill
    output logic [gnafs_pkg::OUT_TDATA_BITS-1:0]        o_m_tdata,
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [gnafs_pkg::CFG_INDEX_BITS-1:0]        i_cfg_index,
    input  logic [gnafs_pkg::LIM_BITS-1:0]              i_cfg_data
);

    localparam int CB  = gnafs_pkg::COORD_BITS;
    localparam int NC  = gnafs_pkg::NUM_COORDS;
    localparam int NP  = gnafs_pkg::NUM_PAIRS;
    localparam int DW  = gnafs_pkg::DIFF_BITS;
    localparam int SW  = gnafs_pkg::SQ_BITS;
    localparam int DSW = gnafs_pkg::DIST_BITS;
    localparam int AW  = gnafs_pkg::ANGLE_BITS;
    localparam int DAW = gnafs_pkg::DA_BITS;
    localparam int CW  = gnafs_pkg::CMP_BITS;
    localparam int LW  = gnafs_pkg::LIM_BITS;
    localparam int FB  = gnafs_pkg::ANGLE_FRAC_BITS;
    localparam int NCS = gnafs_pkg::CORDIC_STAGES;
    localparam int NPS = gnafs_pkg::PIPE_STAGES;
    localparam int PAD = gnafs_pkg::OUT_TDATA_BITS - gnafs_pkg::RESULT_BITS;

    logic                 r_vld [NPS];
    logic                 en;

    logic [LW-1:0]        r_wide_limit, r_swap_limit;

    logic [CB-1:0]        c_in  [NC];
    logic [CB-1:0]        r1_c  [NC];
    logic [SW-1:0]        r1_sq [2*NP];
    logic [CB-1:0]        r2_c  [NC];
    logic [DSW-1:0]       r2_dist [NP];
    logic [CB-1:0]        r3_pt [NC];
    logic [1:0]           r3_near;

    logic                 n_lo_sel, n_hi_sel, n_hi_win;
    logic [DSW-1:0]       n_lo_min, n_hi_min;
    logic [1:0]           n_near;

    logic signed [DW-1:0] dx0, dy0, dx1, dy1;
    logic signed [AW-1:0] a0, a1;
    logic [1:0]           r_near_cd [NCS];

    logic signed [AW-1:0]  r4_a0, r4_a1;
    logic signed [DAW-1:0] r4_d;
    logic [1:0]            r4_near;

    logic signed [DAW-1:0] n_ad;
    logic signed [CW-1:0]  n_d_ext, n_ad_ext, n_wide_ext, n_swap_ext;
    logic                  n_swap;
    gnafs_pkg::t_result    r5_res;

    gnafs_pkg::t_result    r_odata, r_sdata;
    logic                  r_ovld, r_svld;
    logic                  take, incoming;

    assign en          = !r_svld;
    assign o_s_tready  = en;
    assign o_cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_limit <= gnafs_pkg::WIDE_LIMIT_RESET;
            r_swap_limit <= gnafs_pkg::SWAP_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gnafs_pkg::CFG_WIDE_LIMIT: r_wide_limit <= i_cfg_data;
                gnafs_pkg::CFG_SWAP_LIMIT: r_swap_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < NPS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    for (genvar k = 0; k < NC; k++) begin : g_unpack
        assign c_in[k] = i_s_tdata[k*CB +: CB];
    end

    // stage 1: squared coordinate differences
    for (genvar p = 0; p < NP; p++) begin : g_pair
        for (genvar ax = 0; ax < 2; ax++) begin : g_axis
            localparam int FA = ((p / 2) * 2) + ax;
            localparam int FBI = 4 + ((p % 2) * 2) + ax;
            logic [CB-1:0] ad;
            assign ad = (c_in[FA] >= c_in[FBI]) ? (c_in[FA] - c_in[FBI])
                                                : (c_in[FBI] - c_in[FA]);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r1_sq[2*p+ax] <= SW'(ad) * SW'(ad);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_c <= c_in;
        end
    end

    // stage 2: squared distances
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_c <= r1_c;
            for (int p = 0; p < NP; p++) begin
                r2_dist[p] <= DSW'(r1_sq[2*p]) + DSW'(r1_sq[2*p+1]);
            end
        end
    end

    // stage 3: closest pair, lowest index on ties; orient segments
    always_comb begin
        n_lo_sel = r2_dist[1] < r2_dist[0];
        n_lo_min = n_lo_sel ? r2_dist[1] : r2_dist[0];
        n_hi_sel = r2_dist[3] < r2_dist[2];
        n_hi_min = n_hi_sel ? r2_dist[3] : r2_dist[2];
        n_hi_win = n_hi_min < n_lo_min;
        n_near   = n_hi_win ? {1'b1, n_hi_sel} : {1'b0, n_lo_sel};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_near <= n_near;
            if (n_near[1]) begin
                r3_pt[0] <= r2_c[2];
                r3_pt[1] <= r2_c[3];
                r3_pt[2] <= r2_c[0];
                r3_pt[3] <= r2_c[1];
            end else begin
                r3_pt[0] <= r2_c[0];
                r3_pt[1] <= r2_c[1];
                r3_pt[2] <= r2_c[2];
                r3_pt[3] <= r2_c[3];
            end
            if (n_near[0]) begin
                r3_pt[4] <= r2_c[6];
                r3_pt[5] <= r2_c[7];
                r3_pt[6] <= r2_c[4];
                r3_pt[7] <= r2_c[5];
            end else begin
                r3_pt[4] <= r2_c[4];
                r3_pt[5] <= r2_c[5];
                r3_pt[6] <= r2_c[6];
                r3_pt[7] <= r2_c[7];
            end
        end
    end

    // dx = start_x - end_x, dy = end_y - start_y
    assign dx0 = $signed({1'b0, r3_pt[0]}) - $signed({1'b0, r3_pt[2]});
    assign dy0 = $signed({1'b0, r3_pt[3]}) - $signed({1'b0, r3_pt[1]});
    assign dx1 = $signed({1'b0, r3_pt[4]}) - $signed({1'b0, r3_pt[6]});
    assign dy1 = $signed({1'b0, r3_pt[7]}) - $signed({1'b0, r3_pt[5]});

    gnafs_cordic u_cordic_first (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_dx    (dx0),
        .i_dy    (dy0),
        .o_angle (a0)
    );

    gnafs_cordic u_cordic_second (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_dx    (dx1),
        .i_dy    (dy1),
        .o_angle (a1)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_near_cd[0] <= r3_near;
            for (int k = 1; k < NCS; k++) begin
                r_near_cd[k] <= r_near_cd[k-1];
            end
        end
    end

    // angle difference
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_a0   <= a0;
            r4_a1   <= a1;
            r4_d    <= {a0[AW-1], a0} - {a1[AW-1], a1};
            r4_near <= r_near_cd[NCS-1];
        end
    end

    // limit rule
    always_comb begin
        n_ad       = r4_d[DAW-1] ? -r4_d : r4_d;
        n_d_ext    = {r4_d[DAW-1], r4_d};
        n_ad_ext   = {n_ad[DAW-1], n_ad};
        n_wide_ext = $signed({{(CW-LW-FB){1'b0}}, r_wide_limit, {FB{1'b0}}});
        n_swap_ext = $signed({{(CW-LW-FB){1'b0}}, r_swap_limit, {FB{1'b0}}});
        n_swap     = (n_ad_ext <= n_wide_ext) && (n_d_ext < n_swap_ext);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_res.angle_one <= n_swap ? r4_a1 : r4_a0;
            r5_res.angle_two <= n_swap ? r4_a0 : r4_a1;
            r5_res.swapped   <= n_swap;
            r5_res.near_pair <= r4_near;
        end
    end

    // output register and skid
    assign take     = r_ovld && i_m_tready;
    assign incoming = r_vld[NPS-1] && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_svld <= 1'b0;
        end else if (r_svld) begin
            if (take) begin
                r_svld <= 1'b0;
            end
        end else if (incoming) begin
            if (!r_ovld || take) begin
                r_ovld <= 1'b1;
            end else begin
                r_svld <= 1'b1;
            end
        end else if (take) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_svld) begin
            if (take) begin
                r_odata <= r_sdata;
            end
        end else if (incoming) begin
            if (!r_ovld || take) begin
                r_odata <= r5_res;
            end else begin
                r_sdata <= r5_res;
            end
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {{PAD{1'b0}}, r_odata};

endmodule

[src/gnafs_checker.sv]
module gnafs_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_tvalid,
    input logic                                 o_s_tready,
    input logic [gnafs_pkg::IN_TDATA_BITS-1:0]  i_s_tdata,
    input logic                                 o_m_tvalid,
    input logic                                 i_m_tready,
    input logic [gnafs_pkg::OUT_TDATA_BITS-1:0] o_m_tdata,
    input logic                                 i_cfg_valid,
    input logic                                 o_cfg_ready,
    input logic [gnafs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input logic [gnafs_pkg::LIM_BITS-1:0]       i_cfg_data
);

    localparam int AW = gnafs_pkg::ANGLE_BITS;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("reset did not empty the output side");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with no result waiting");

    a_block_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_tready) |-> $past(o_m_tvalid && !i_m_tready))
        else $error("input blocked without an output stall");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            ($signed(o_m_tdata[AW-1:0]) <= gnafs_pkg::FULL_ANGLE) &&
            ($signed(o_m_tdata[AW-1:0]) >= gnafs_pkg::NEG_FULL) &&
            ($signed(o_m_tdata[2*AW-1:AW]) <= gnafs_pkg::FULL_ANGLE) &&
            ($signed(o_m_tdata[2*AW-1:AW]) >= gnafs_pkg::NEG_FULL))
        else $error("angle beyond half turn");

endmodule

bind gauge_needle_angle_from_segments_unit gnafs_checker u_gnafs_checker (.*);

[test/tb.sv]
module tb;
    import gnafs_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 150;
    localparam int HOLD_AT     = 350;
    localparam int PHASE_ITEMS = 215;
    localparam int NUM_PHASES  = 6;

    // index values that map to no register
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LOW  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HIGH = 2'd3;

    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [IN_TDATA_BITS-1:0]      i_s_tdata = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0]     o_m_tdata;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     i_cfg_index = '0;
    logic [LIM_BITS-1:0]           i_cfg_data = '0;

    gauge_needle_angle_from_segments_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [IN_TDATA_BITS-1:0] pending_pairs [$];
    t_result                  awaited_readings [$];
    logic [LIM_BITS-1:0]      wide_limit = WIDE_LIMIT_RESET;
    logic [LIM_BITS-1:0]      swap_limit = SWAP_LIMIT_RESET;
    int                       error_count = 0;
    int                       readings_seen = 0;
    int                       quiet_cycles = 0;
    bit                       s_fire = 1'b0;

    function automatic longint edge_angle(input longint dy, input longint dx);
        longint full, base, x, y, z, xs, ys, t, r;
        int     i;
        full = longint'(180) <<< ANGLE_FRAC_BITS;
        base = 0;
        x = dx;
        y = dy;
        z = 0;
        if (dy == 0)
            return (dx < 0) ? full : 0;
        if (dx == 0)
            return (dy > 0) ? (longint'(90) <<< ANGLE_FRAC_BITS)
                            : -(longint'(90) <<< ANGLE_FRAC_BITS);
        if (dx < 0) begin
            base = (dy > 0) ? (longint'(180) <<< TAB_FRAC) : -(longint'(180) <<< TAB_FRAC);
            x = -dx;
            y = -dy;
        end
        x = x * (longint'(1) <<< PRE_SHIFT);
        y = y * (longint'(1) <<< PRE_SHIFT);
        for (i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(STEP_ANGLE[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(STEP_ANGLE[i]);
            end
        end
        t = base + z + (longint'(1) <<< (RND_SHIFT - 1));
        r = t >>> RND_SHIFT;
        if (r > full)
            r = full;
        if (r < -full)
            r = -full;
        return r;
    endfunction

    function automatic t_result predict_needle(input logic [IN_TDATA_BITS-1:0] pair);
        longint     c [NUM_COORDS];
        longint     gap_sq [NUM_PAIRS];
        longint     best, s0x, s0y, e0x, e0y, s1x, s1y, e1x, e1y, a0, a1, d, ad;
        logic [1:0] near;
        logic       swap;
        t_result    r;
        int         k;
        for (k = 0; k < NUM_COORDS; k++)
            c[k] = longint'(pair[k*COORD_BITS +: COORD_BITS]);
        gap_sq[0] = (c[0]-c[4])*(c[0]-c[4]) + (c[1]-c[5])*(c[1]-c[5]);
        gap_sq[1] = (c[0]-c[6])*(c[0]-c[6]) + (c[1]-c[7])*(c[1]-c[7]);
        gap_sq[2] = (c[2]-c[4])*(c[2]-c[4]) + (c[3]-c[5])*(c[3]-c[5]);
        gap_sq[3] = (c[2]-c[6])*(c[2]-c[6]) + (c[3]-c[7])*(c[3]-c[7]);
        best = gap_sq[0];
        near = 2'd0;
        for (k = 1; k < NUM_PAIRS; k++) begin
            if (gap_sq[k] < best) begin
                best = gap_sq[k];
                near = k[1:0];
            end
        end
        if (near[1]) begin
            s0x = c[2]; s0y = c[3]; e0x = c[0]; e0y = c[1];
        end else begin
            s0x = c[0]; s0y = c[1]; e0x = c[2]; e0y = c[3];
        end
        if (near[0]) begin
            s1x = c[6]; s1y = c[7]; e1x = c[4]; e1y = c[5];
        end else begin
            s1x = c[4]; s1y = c[5]; e1x = c[6]; e1y = c[7];
        end
        a0 = edge_angle(e0y - s0y, s0x - e0x);
        a1 = edge_angle(e1y - s1y, s1x - e1x);
        d = a0 - a1;
        ad = (d < 0) ? -d : d;
        swap = (ad <= (longint'(wide_limit) <<< ANGLE_FRAC_BITS)) &&
               (d < (longint'(swap_limit) <<< ANGLE_FRAC_BITS));
        r.angle_one = ANGLE_BITS'(swap ? a1 : a0);
        r.angle_two = ANGLE_BITS'(swap ? a0 : a1);
        r.swapped   = swap;
        r.near_pair = near;
        return r;
    endfunction

    function automatic logic [IN_TDATA_BITS-1:0] random_pair();
        int                       c [NUM_COORDS];
        int                       px, py, vx, vy, ox, oy, jx, jy, sel, k, tmp;
        logic [IN_TDATA_BITS-1:0] word;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            for (k = 0; k < NUM_COORDS; k++)
                c[k] = $urandom_range(0, COORD_MAX);
        end else if (sel < 35) begin
            for (k = 0; k < NUM_COORDS; k++)
                c[k] = $urandom_range(0, 1) ? int'(COORD_MAX) : 0;
        end else begin
            // two nearly parallel needle edges around a common hub
            px = $urandom_range(300, 3795);
            py = $urandom_range(300, 3795);
            vx = int'($urandom_range(0, 500)) - 250;
            vy = int'($urandom_range(0, 500)) - 250;
            ox = int'($urandom_range(0, 16)) - 8;
            oy = int'($urandom_range(0, 16)) - 8;
            jx = int'($urandom_range(0, 20)) - 10;
            jy = int'($urandom_range(0, 20)) - 10;
            if (sel < 45) begin
                if ($urandom_range(0, 1))
                    vx = 0;
                else
                    vy = 0;
                jx = 0;
                jy = 0;
            end else if (sel < 48) begin
                vx = 0;
                vy = 0;
                jx = 0;
                jy = 0;
            end
            c[0] = px;           c[1] = py;
            c[2] = px + vx;      c[3] = py + vy;
            c[4] = px + ox;      c[5] = py + oy;
            c[6] = c[4] + vx + jx;
            c[7] = c[5] + vy + jy;
            if ($urandom_range(0, 1)) begin
                tmp = c[0]; c[0] = c[2]; c[2] = tmp;
                tmp = c[1]; c[1] = c[3]; c[3] = tmp;
            end
            if ($urandom_range(0, 1)) begin
                tmp = c[4]; c[4] = c[6]; c[6] = tmp;
                tmp = c[5]; c[5] = c[7]; c[7] = tmp;
            end
        end
        for (k = 0; k < NUM_COORDS; k++)
            word[k*COORD_BITS +: COORD_BITS] = COORD_BITS'(c[k]);
        return word;
    endfunction

    task automatic queue_pair(input int fsx, input int fsy, input int fex, input int fey,
                              input int ssx, input int ssy, input int sex, input int sey);
        pending_pairs.insert(pending_pairs.size(),
                             {COORD_BITS'(sey), COORD_BITS'(sex), COORD_BITS'(ssy),
                              COORD_BITS'(ssx), COORD_BITS'(fey), COORD_BITS'(fex),
                              COORD_BITS'(fsy), COORD_BITS'(fsx)});
    endtask

    task automatic write_limit(input logic [CFG_INDEX_BITS-1:0] idx,
                               input logic [LIM_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_WIDE_LIMIT)
            wide_limit = val;
        else if (idx == CFG_SWAP_LIMIT)
            swap_limit = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_pairs.size() != 0 || i_s_tvalid || awaited_readings.size() != 0);
    endtask

    // sender: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge i_clk) begin
        if (!i_s_tvalid || s_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                i_s_tdata  <= pending_pairs.pop_front();
                i_s_tvalid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern set by rx_cycle[8:7], one long hold-off
    logic [15:0] rx_cycle = '0;
    int          rx_hold = 0;
    bit          rx_long_done = 1'b0;

    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 16'd1;
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_tready <= 1'b0;
        end else if (!rx_long_done && readings_seen >= HOLD_AT) begin
            rx_long_done = 1'b1;
            rx_hold = LONG_HOLD;
            i_m_tready <= 1'b0;
        end else begin
            case (rx_cycle[8:7])
                2'd0: begin
                    i_m_tready <= 1'b1;
                end
                2'd1: begin
                    i_m_tready <= 1'($urandom_range(0, 1));
                end
                2'd2: begin
                    i_m_tready <= (rx_cycle[1:0] == 2'd0);
                end
                default: begin
                    i_m_tready <= ($urandom_range(0, 7) != 0);
                end
            endcase
        end
    end

    // monitor, checker and watchdog
    t_result got_reading;
    t_result want_reading;
    bit      m_fire;

    always @(posedge i_clk) begin
        s_fire = i_rst_n && i_s_tvalid && o_s_tready;
        m_fire = i_rst_n && o_m_tvalid && i_m_tready;
        if (s_fire)
            awaited_readings.insert(awaited_readings.size(), predict_needle(i_s_tdata));
        if (m_fire) begin
            got_reading = o_m_tdata[RESULT_BITS-1:0];
            readings_seen++;
            if (awaited_readings.size() == 0) begin
                $error("unexpected result transaction: %h", o_m_tdata);
                error_count++;
            end else begin
                want_reading = awaited_readings.pop_front();
                if (got_reading.angle_one !== want_reading.angle_one) begin
                    $error("angle_one: expected %0d, actual %0d",
                           want_reading.angle_one, got_reading.angle_one);
                    error_count++;
                end
                if (got_reading.angle_two !== want_reading.angle_two) begin
                    $error("angle_two: expected %0d, actual %0d",
                           want_reading.angle_two, got_reading.angle_two);
                    error_count++;
                end
                if (got_reading.swapped !== want_reading.swapped) begin
                    $error("swapped: expected %0d, actual %0d",
                           want_reading.swapped, got_reading.swapped);
                    error_count++;
                end
                if (got_reading.near_pair !== want_reading.near_pair) begin
                    $error("near_pair: expected %0d, actual %0d",
                           want_reading.near_pair, got_reading.near_pair);
                    error_count++;
                end
            end
        end
        if (s_fire || m_fire || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    logic [LIM_BITS-1:0] phase_wide [NUM_PHASES];
    logic [LIM_BITS-1:0] phase_swap [NUM_PHASES];

    initial begin
        int p, n;
        phase_wide = '{8'd0, 8'd255, 8'd180, 8'd20,  8'd45, 8'd0};
        phase_swap = '{8'd0, 8'd255, 8'd0,   8'd180, 8'd36, 8'd0};
        phase_wide[NUM_PHASES-1] = $urandom_range(0, 255);
        phase_swap[NUM_PHASES-1] = $urandom_range(0, 255);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // writes to unused indexes must leave the limits alone
        write_limit(CFG_SPARE_LOW, 8'hFF);
        write_limit(CFG_SPARE_HIGH, 8'h00);

        // directed items under reset limits
        queue_pair(0, 0, 0, 0, 0, 0, 0, 0);
        queue_pair(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
        queue_pair(0, 0, 4095, 4095, 4095, 4095, 0, 0);
        queue_pair(0, 0, 100, 100, 101, 100, 4095, 4095);
        queue_pair(0, 0, 2000, 2000, 4095, 0, 2001, 2000);
        queue_pair(100, 500, 900, 500, 100, 510, 4095, 510);
        queue_pair(900, 500, 100, 500, 900, 520, 0, 520);
        queue_pair(500, 100, 500, 900, 510, 100, 510, 4000);
        queue_pair(500, 900, 500, 100, 510, 900, 510, 0);
        queue_pair(0, 0, 3000, 1000, 10, 0, 3000, 4000);
        queue_pair(0, 4095, 4095, 0, 5, 4090, 4000, 10);
        queue_pair(1000, 1000, 1000, 2000, 1010, 1000, 1810, 1800);
        queue_pair(1000, 1000, 1000, 2000, 1010, 1000, 210, 1800);
        queue_pair(1000, 1000, 1000, 0, 1000, 1001, 1000, 3000);
        queue_pair(2000, 2000, 2000, 2500, 2001, 2000, 1500, 2500);
        queue_pair(100, 100, 300, 100, 110, 100, 90, 100);
        queue_pair(0, 0, 200, 0, 210, 0, 10, 0);
        queue_pair(2048, 2048, 2048, 2048, 2048, 2048, 1024, 3072);
        queue_pair(4095, 0, 0, 4095, 0, 4095, 4095, 0);
        for (n = 0; n < 5; n++)
            pending_pairs.insert(pending_pairs.size(), random_pair());
        wait_drained();

        for (p = 0; p < NUM_PHASES; p++) begin
            write_limit(CFG_WIDE_LIMIT, phase_wide[p]);
            write_limit(CFG_SWAP_LIMIT, phase_swap[p]);
            for (n = 0; n < PHASE_ITEMS; n++)
                pending_pairs.insert(pending_pairs.size(), random_pair());
            wait_drained();
        end

        repeat (PIPE_STAGES + 8) @(posedge i_clk);
        if (awaited_readings.size() != 0) begin
            $error("%0d results never arrived", awaited_readings.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

[files.f]
src/gnafs_pkg.sv
src/gnafs_cordic.sv
src/gauge_needle_angle_from_segments_unit.sv
src/gnafs_checker.sv
test/tb.sv
